// File: src/uatx_pkg.sv
// ============================================================================
// uatx_pkg
// Shared word types, character type, front-end states and constants for the
// serial transmit framer.
// ============================================================================
package uatx_pkg;

    // Input word: command and byte.
    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } t_in_word;

    // Output word: one line level per bit period.
    typedef struct packed {
        logic line_level;
        logic last;
    } t_out_word;

    // Character queued between front and back; last marks the item's final one.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char;

    typedef enum logic [2:0] {
        F_IDLE,
        F_RAW,
        F_HUND,
        F_TENS,
        F_UNITS
    } t_front_state;

    localparam logic       CMD_RAW    = 1'b0;
    localparam logic       CMD_DEC    = 1'b1;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

endpackage

// File: src/uatx_front.sv
// ============================================================================
// uatx_front
// Accepts input words, splits decimal bytes into digits and queues characters.
// ============================================================================
module uatx_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  uatx_pkg::t_in_word i_in_word,
    input  logic              i_q_full,
    output logic              o_q_push,
    output uatx_pkg::t_char   o_q_char
);
    import uatx_pkg::*;

    t_front_state r_state;
    t_front_state n_state;

    logic [7:0]  r_data;
    logic [1:0]  r_hund;
    logic [3:0]  r_tens;
    logic [3:0]  r_units;

    logic [1:0]  w_hund;
    logic [7:0]  w_rem8;
    logic [6:0]  w_rem;
    logic [14:0] w_prod;
    logic [3:0]  w_tens;
    logic [6:0]  w_tens10;
    logic [3:0]  w_units;

    // Split into digits: compares for hundreds, reciprocal multiply for tens.
    always_comb begin
        if (i_in_word.data >= 8'd200) begin
            w_hund = 2'd2;
            w_rem8 = i_in_word.data - 8'd200;
        end else if (i_in_word.data >= 8'd100) begin
            w_hund = 2'd1;
            w_rem8 = i_in_word.data - 8'd100;
        end else begin
            w_hund = 2'd0;
            w_rem8 = i_in_word.data;
        end
        w_rem    = w_rem8[6:0];
        // 205 / 2048 is exact enough for remainders below 100
        w_prod   = 15'(w_rem) * 15'd205;
        w_tens   = w_prod[14:11];
        w_tens10 = {w_tens, 3'b000} + {2'b00, w_tens, 1'b0};
        w_units  = 4'(w_rem - w_tens10);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_data  <= i_in_word.data;
            r_hund  <= w_hund;
            r_tens  <= w_tens;
            r_units <= w_units;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_q_push      = 1'b0;
        o_q_char.ch   = 8'h00;
        o_q_char.last = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_word.cmd == CMD_RAW) begin
                        n_state = F_RAW;
                    end else if (w_hund != 2'd0) begin
                        n_state = F_HUND;
                    end else if (w_tens != 4'd0) begin
                        n_state = F_TENS;
                    end else begin
                        n_state = F_UNITS;
                    end
                end
            end
            F_RAW: begin
                o_q_char.ch   = r_data;
                o_q_char.last = 1'b1;
                o_q_push      = !i_q_full;
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            F_HUND: begin
                o_q_char.ch = ASCII_ZERO + {6'd0, r_hund};
                o_q_push    = !i_q_full;
                // keep a middle zero once hundreds is sent
                if (!i_q_full) begin
                    n_state = F_TENS;
                end
            end
            F_TENS: begin
                o_q_char.ch = ASCII_ZERO + {4'd0, r_tens};
                o_q_push    = !i_q_full;
                if (!i_q_full) begin
                    n_state = F_UNITS;
                end
            end
            F_UNITS: begin
                o_q_char.ch   = ASCII_ZERO + {4'd0, r_units};
                o_q_char.last = 1'b1;
                o_q_push      = !i_q_full;
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

endmodule

// File: src/uatx_fifo.sv
// ============================================================================
// uatx_fifo
// Short character queue that decouples the front end from the bit framer.
// ============================================================================
module uatx_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  uatx_pkg::t_char i_push_char,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nempty,
    output uatx_pkg::t_char o_head
);
    import uatx_pkg::*;

    t_char             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;

    logic w_push;
    logic w_pop;

    assign o_full   = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_nempty = (r_count != '0);
    assign o_head   = r_mem[r_rd_ptr];
    assign w_push   = i_push && !o_full;
    assign w_pop    = i_pop && o_nempty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: src/uatx_back.sv
// ============================================================================
// uatx_back
// Frames queued characters into start, data and stop levels, one per bit time.
// ============================================================================
module uatx_back #(
    parameter int DATA_BITS = 8,
    parameter int STOP_BITS = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_bit_period,
    input  logic                i_q_nempty,
    input  uatx_pkg::t_char     i_q_head,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output uatx_pkg::t_out_word o_out_word
);
    import uatx_pkg::*;

    localparam int FRAME_LEN = 1 + DATA_BITS + STOP_BITS;
    localparam int POS_W     = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_DATA_END = POS_W'(DATA_BITS);

    logic [POS_W-1:0]     r_pos;
    logic [DATA_BITS-1:0] r_shift;
    logic                 r_lastc;
    logic [8:0]           r_timer;
    logic                 r_out_valid;
    t_out_word            r_out_word;

    logic      w_slot_free;
    logic      w_load;
    logic [8:0] w_period;
    t_out_word w_word;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_load      = (r_timer == 9'd0) && w_slot_free && ((r_pos != '0) || i_q_nempty);
    assign o_q_pop     = w_load && (r_pos == '0);
    assign w_period    = (i_bit_period == 8'd0) ? 9'd256 : {1'b0, i_bit_period};

    always_comb begin
        if (r_pos == '0) begin
            w_word.line_level = 1'b0;
        end else if (r_pos <= POS_DATA_END) begin
            w_word.line_level = r_shift[0];
        end else begin
            w_word.line_level = 1'b1;
        end
        w_word.last = r_lastc && (r_pos == POS_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_timer     <= 9'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_timer     <= w_period - 9'd1;
                r_out_valid <= 1'b1;
                r_pos       <= (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
            end else begin
                if (r_timer != 9'd0) begin
                    r_timer <= r_timer - 9'd1;
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_word <= w_word;
            if (r_pos == '0) begin
                r_shift <= i_q_head.ch[DATA_BITS-1:0];
                r_lastc <= i_q_head.last;
            end else if (r_pos <= POS_DATA_END) begin
                r_shift <= r_shift >> 1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: src/uart_tx_byte_and_decimal_core.sv
// ============================================================================
// uart_tx_byte_and_decimal_core
// Serial transmit framer: raw bytes or decimal ASCII digits, framed as
// start bit, LSB-first data bits and stop bits, one output word per level.
// ============================================================================
// Each input word carries a byte and a command. Raw command sends the byte as
// one character; decimal command sends it as one to three ASCII digits with
// leading zeros suppressed (a middle zero after a nonzero hundreds digit is
// kept). Every character leaves as 1 + DATA_BITS + STOP_BITS output words, one
// line level each: low start bit, data bits LSB first, high stop bits. The
// final word of an input item carries last. Output words are spaced by the
// bit timer in the back end, set by bit_period (zero means 256). The front
// end splits digits and queues characters in a four-entry queue, so it takes
// the next input word while the back end is still shifting out the previous
// one; a result word sits in the output register while the framer prepares
// the next. Write bit_period only while the block is idle.
module uart_tx_byte_and_decimal_core #(
    parameter int DATA_BITS = 8,
    parameter int STOP_BITS = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write channel: bit_period
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data,
    // input words
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  uatx_pkg::t_in_word  i_in_word,
    // output words
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output uatx_pkg::t_out_word o_out_word
);
    import uatx_pkg::*;

    logic [7:0] r_bit_period;

    logic  w_q_push;
    t_char w_q_char;
    logic  w_q_full;
    logic  w_q_pop;
    logic  w_q_nempty;
    t_char w_q_head;

    // Always take configuration writes; hold the bit period until rewritten.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= 8'd0;
        end else if (i_cfg_valid) begin
            r_bit_period <= i_cfg_data;
        end
    end

    // Front end: accept, classify and split into characters.
    uatx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_char   (w_q_char)
    );

    // Character queue between the two halves.
    uatx_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_q_push),
        .i_push_char (w_q_char),
        .o_full      (w_q_full),
        .i_pop       (w_q_pop),
        .o_nempty    (w_q_nempty),
        .o_head      (w_q_head)
    );

    // Back end: frame characters into line levels at the bit rate.
    uatx_back #(
        .DATA_BITS (DATA_BITS),
        .STOP_BITS (STOP_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bit_period (r_bit_period),
        .i_q_nempty   (w_q_nempty),
        .i_q_head     (w_q_head),
        .o_q_pop      (w_q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the serial transmit framer. Raw and decimal words
// are pushed in under random idle gaps and output backpressure, and every
// line level that comes out is compared against a local frame predictor.
// ============================================================================
module tb;

    import uatx_pkg::*;

    localparam int TB_DATA_BITS = 8;
    localparam int TB_STOP_BITS = 2;
    localparam int CLK_HALF     = 5;
    localparam int SETTLE_CYCLES = 600;        // covers two stop bits at period 256
    localparam int HOLD_CYCLES   = 400;        // long output hold-off

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out_word;

    // Line levels still owed by the block, oldest first.
    t_out_word   pending_levels[$];
    int          fail_count   = 0;
    bit          src_gaps     = 1'b0;   // sender inserts idle gaps
    bit          sink_gaps    = 1'b0;   // receiver drops ready at random
    int          hold_request = 0;      // cycles of forced hold-off, picked up by the sink

    uart_tx_byte_and_decimal_core #(
        .DATA_BITS (TB_DATA_BITS),
        .STOP_BITS (TB_STOP_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Gap length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------------
    task automatic push_level(input logic level, input logic is_last);
        t_out_word lv;
        lv.line_level = level;
        lv.last       = is_last;
        pending_levels.push_back(lv);
    endtask

    // Queue one character frame: start bit low, data LSB first, stop bits high.
    // Only the final stop bit of the item's final character carries last.
    task automatic push_char_frame(input logic [7:0] ch, input logic end_of_item);
        push_level(1'b0, 1'b0);
        for (int b = 0; b < TB_DATA_BITS; b++) begin
            push_level(ch[b], 1'b0);
        end
        for (int s = 0; s < TB_STOP_BITS; s++) begin
            push_level(1'b1, end_of_item && (s == TB_STOP_BITS - 1));
        end
    endtask

    // Expand one accepted input word into the levels it must produce.
    task automatic expand_word(input t_in_word w);
        logic [7:0] hund;
        logic [7:0] tens;
        logic [7:0] units;
        if (w.cmd == CMD_RAW) begin
            push_char_frame(w.data, 1'b1);
        end else begin
            hund  = w.data / 8'd100;
            tens  = (w.data / 8'd10) % 8'd10;
            units = w.data % 8'd10;
            // suppress leading zeros, but keep a middle zero after a hundreds digit
            if (hund != 8'd0) begin
                push_char_frame(ASCII_ZERO + hund, 1'b0);
            end
            if (hund != 8'd0 || tens != 8'd0) begin
                push_char_frame(ASCII_ZERO + tens, 1'b0);
            end
            push_char_frame(ASCII_ZERO + units, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------------
    // Offer one word and hold it until the block takes it. Valid is only
    // dropped when a gap is inserted, so back-to-back words keep it high.
    task automatic send_word(input logic cmd, input logic [7:0] data);
        t_in_word w;
        int       gap;
        w.cmd  = cmd;
        w.data = data;
        gap    = src_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        expand_word(w);
    endtask

    // Drop valid and wait until every owed level has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
    endtask

    // Write bit_period; call only with the block drained.
    task automatic write_bit_period(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_byte();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) begin
            return 8'($urandom_range(0, 9));       // single digit
        end else if (r == 1) begin
            return 8'($urandom_range(10, 99));     // two digits
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset leaves bit_period at zero, i.e. the slowest rate of 256.
    task automatic test_reset_period();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        send_word(CMD_RAW, 8'hA5);
        send_word(CMD_DEC, 8'd7);
        drain();
    endtask

    task automatic test_raw_extremes();
        write_bit_period(8'd1);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        send_word(CMD_RAW, 8'h00);
        send_word(CMD_RAW, 8'hFF);
        send_word(CMD_RAW, 8'h55);
        send_word(CMD_RAW, 8'hAA);
        send_word(CMD_RAW, 8'h01);
        send_word(CMD_RAW, 8'h80);
        drain();
    endtask

    // Zero, digit boundaries and middle zeros.
    task automatic test_decimal_digits();
        logic [7:0] vals[12] = '{8'd0, 8'd1, 8'd9, 8'd10, 8'd50, 8'd99,
                                 8'd100, 8'd101, 8'd105, 8'd110, 8'd200, 8'd255};
        foreach (vals[k]) begin
            send_word(CMD_DEC, vals[k]);
        end
        drain();
    endtask

    // Hold the receiver off while words keep coming, so the character queue
    // and output register fill and the input side has to stall.
    task automatic test_input_backpressure();
        src_gaps     = 1'b0;
        sink_gaps    = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int k = 0; k < 12; k++) begin
            send_word(1'($urandom_range(0, 1)), random_byte());
        end
        drain();
    endtask

    task automatic random_phase(input logic [7:0] period, input int count,
                                input bit gaps);
        write_bit_period(period);
        src_gaps  = gaps;
        sink_gaps = gaps;
        for (int k = 0; k < count; k++) begin
            send_word(1'($urandom_range(0, 1)), random_byte());
        end
        drain();
    endtask

    // Sweep the rate from fastest to slowest and back to fast; keep the slow phases short.
    task automatic test_random_traffic();
        random_phase(8'd1,   56, 1'b1);
        random_phase(8'd2,   45, 1'b1);
        random_phase(8'd7,   35, 1'b1);
        random_phase(8'd255,  4, 1'b1);
        random_phase(8'd0,    3, 1'b1);
        random_phase(8'd3,   15, 1'b1);
        random_phase(8'd1,   30, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 8'd0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_period();
        test_raw_extremes();
        test_decimal_digits();
        test_input_backpressure();
        test_random_traffic();

        // Let any stray word show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_levels.size() != 0) begin
            $display("%0t: %0d level(s) never arrived", $time, pending_levels.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus the long hold-off counted here
    // ------------------------------------------------------------------------
    initial begin : sink
        int hold_left;
        int stall_left;
        hold_left   = 0;
        stall_left  = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (sink_gaps) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each accepted word with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_word
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_levels.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual level=%b last=%b",
                         $time, o_out_word.line_level, o_out_word.last);
                fail_count++;
            end else begin
                want = pending_levels.pop_front();
                if (o_out_word.line_level !== want.line_level) begin
                    $display("%0t: line_level mismatch, expected %b actual %b",
                             $time, want.line_level, o_out_word.line_level);
                    fail_count++;
                end
                if (o_out_word.last !== want.last) begin
                    $display("%0t: last mismatch, expected %b actual %b",
                             $time, want.last, o_out_word.last);
                    fail_count++;
                end
            end
        end
    end

    // Hard stop if the block hangs.
    initial begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
